@@ design/fcd_pkg.sv @@
package fcd_pkg;

	localparam logic [1:0] KIND_BRUN = 2'd0;
	localparam logic [1:0] KIND_LC   = 2'd1;
	localparam logic [1:0] KIND_SS2  = 2'd2;
	localparam logic [1:0] KIND_COPY = 2'd3;

	localparam int OUT_DATA_W = 48;

	// One span write, or a bare chunk-done mark.
	typedef struct packed {
		logic       write_valid;
		logic [9:0] row;
		logic [9:0] column;
		logic [7:0] span_length;
		logic [7:0] byte_a;
		logic [7:0] byte_b;
		logic       pattern_two;
		logic       chunk_done;
	} fcd_res_t;

	// What the parser hands to the result queue for one parsed byte.
	typedef struct packed {
		logic     push;
		logic     two;
		fcd_res_t r0;
		fcd_res_t r1;
	} fcd_push_t;

endpackage

@@ design/fcd_parser.sv @@
module fcd_parser import fcd_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  payload_byte,
	input  logic [1:0]  chunk_kind,
	input  logic        first_byte,
	input  logic [10:0] frame_width,
	input  logic [10:0] frame_height,
	output fcd_push_t   push_out
);

	localparam logic [3:0] P_IDLE  = 4'd0;
	localparam logic [3:0] P_H0    = 4'd1;
	localparam logic [3:0] P_H1    = 4'd2;
	localparam logic [3:0] P_H2    = 4'd3;
	localparam logic [3:0] P_H3    = 4'd4;
	localparam logic [3:0] P_LINE  = 4'd5;
	localparam logic [3:0] P_WHI   = 4'd6;
	localparam logic [3:0] P_SKIP  = 4'd7;
	localparam logic [3:0] P_COUNT = 4'd8;
	localparam logic [3:0] P_LIT   = 4'd9;
	localparam logic [3:0] P_FILL  = 4'd10;
	localparam logic [3:0] P_FILL2 = 4'd11;
	localparam logic [3:0] P_COPY  = 4'd12;

	logic [3:0]  phase_q;
	logic [1:0]  kind_q;
	logic [15:0] lines_q, row_q, col_q, packets_q;
	logic [7:0]  run_q, low_q, fill_q, edge_val_q;
	logic        edge_pend_q;

	logic [3:0]  phase_d;
	logic [1:0]  kind_d;
	logic [15:0] lines_d, row_d, col_d, packets_d;
	logic [7:0]  run_d, low_d, fill_d, edge_val_d;
	logic        edge_pend_d;

	logic [12:0] eff_w, eff_h;

	assign eff_w = ({2'b0, frame_width} < 13'(MAX_WIDTH)) ? {2'b0, frame_width}
		: 13'(MAX_WIDTH);
	assign eff_h = ({2'b0, frame_height} < 13'(MAX_HEIGHT)) ? {2'b0, frame_height}
		: 13'(MAX_HEIGHT);

	function automatic logic [15:0] adv(input logic [15:0] c, input logic [8:0] n);
		logic [16:0] s;
		s = {1'b0, c} + 17'(n);
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	function automatic fcd_res_t span(input logic [15:0] r, input logic [15:0] c,
		input logic [8:0] len, input logic [7:0] a, input logic [7:0] b,
		input logic two, input logic [12:0] ew, input logic [12:0] eh);
		fcd_res_t    o;
		logic [15:0] room;
		logic [15:0] l;
		o = '0;
		room = {3'b0, ew} - c;
		l = ({7'b0, len} > room) ? room : {7'b0, len};
		if (l > 16'd255) l = 16'd255;
		o.write_valid = (r < {3'b0, eh}) && (c < {3'b0, ew}) && (len != 9'd0);
		o.row         = r[9:0];
		o.column      = c[9:0];
		o.span_length = l[7:0];
		o.byte_a      = a;
		o.byte_b      = two ? b : 8'd0;
		o.pattern_two = two;
		return o;
	endfunction

	always_comb begin
		fcd_res_t   e;
		fcd_res_t   r0, r1;
		logic [1:0] cnt;
		logic       done, take, ev_run, ev_pkt, ev_line;
		logic [15:0] w;
		logic [8:0]  n;

		phase_d = phase_q; kind_d = kind_q; lines_d = lines_q; row_d = row_q;
		col_d = col_q; packets_d = packets_q; run_d = run_q; low_d = low_q;
		fill_d = fill_q; edge_pend_d = edge_pend_q; edge_val_d = edge_val_q;
		r0 = '0; r1 = '0; cnt = 2'd0; done = 1'b0;
		ev_run = 1'b0; ev_pkt = 1'b0; ev_line = 1'b0;
		e = '0; w = '0; n = '0;

		if (first_byte) begin
			kind_d = chunk_kind; row_d = '0; col_d = '0; packets_d = '0; run_d = '0;
			low_d = '0; fill_d = '0; edge_pend_d = 1'b0; edge_val_d = '0;
			lines_d = {5'b0, frame_height};
			if (chunk_kind == KIND_BRUN) begin
				if (frame_height == 11'd0) done = 1'b1; else phase_d = P_LINE;
			end else if (chunk_kind == KIND_COPY) begin
				if (frame_height == 11'd0 || frame_width == 11'd0) done = 1'b1;
				else phase_d = P_COPY;
			end else begin
				lines_d = '0;
				phase_d = P_H0;
			end
			take = !done;
		end else begin
			take = (phase_q != P_IDLE);
		end

		if (take) begin
			unique case (phase_d)
				P_H0: begin
					low_d = payload_byte;
					phase_d = P_H1;
				end
				P_H1: begin
					w = {payload_byte, low_d};
					if (kind_d == KIND_LC) begin
						row_d = w;
						phase_d = P_H2;
					end else begin
						lines_d = w;
						if (w == 16'd0) done = 1'b1; else phase_d = P_LINE;
					end
				end
				P_H2: begin
					low_d = payload_byte;
					phase_d = P_H3;
				end
				P_H3: begin
					lines_d = {payload_byte, low_d};
					if (lines_d == 16'd0) done = 1'b1; else phase_d = P_LINE;
				end
				P_LINE: begin
					col_d = '0;
					if (kind_d == KIND_BRUN) begin
						if (frame_width == 11'd0) ev_line = 1'b1; else phase_d = P_COUNT;
					end else if (kind_d == KIND_LC) begin
						packets_d = {8'b0, payload_byte};
						if (payload_byte == 8'd0) ev_line = 1'b1; else phase_d = P_SKIP;
					end else begin
						low_d = payload_byte;
						phase_d = P_WHI;
					end
				end
				P_WHI: begin
					w = {payload_byte, low_d};
					phase_d = P_LINE;
					case (w[15:14])
						2'b11: row_d = row_d - w;
						2'b10: begin
							edge_pend_d = 1'b1;
							edge_val_d = w[7:0];
						end
						2'b00: begin
							packets_d = w;
							col_d = '0;
							if (w == 16'd0) ev_line = 1'b1; else phase_d = P_SKIP;
						end
						default: ;
					endcase
				end
				P_SKIP: begin
					col_d = adv(col_d, {1'b0, payload_byte});
					phase_d = P_COUNT;
				end
				P_COUNT: begin
					if (payload_byte == 8'd0) begin
						if (kind_d != KIND_BRUN) ev_pkt = 1'b1;
					end else if (!payload_byte[7]) begin
						if (kind_d == KIND_BRUN) begin
							run_d = payload_byte;
							phase_d = P_FILL;
						end else begin
							run_d = (kind_d == KIND_SS2) ? {payload_byte[6:0], 1'b0}
								: payload_byte;
							phase_d = P_LIT;
						end
					end else begin
						run_d = ~payload_byte + 8'd1;
						phase_d = (kind_d == KIND_BRUN) ? P_LIT : P_FILL;
					end
				end
				P_LIT: begin
					e = span(row_d, col_d, 9'd1, payload_byte, 8'd0, 1'b0, eff_w, eff_h);
					if (e.write_valid) begin r0 = e; cnt = 2'd1; end
					col_d = adv(col_d, 9'd1);
					run_d = run_d - 8'd1;
					if (run_d == 8'd0) ev_run = 1'b1;
				end
				P_FILL: begin
					if (kind_d == KIND_SS2) begin
						fill_d = payload_byte;
						phase_d = P_FILL2;
					end else begin
						e = span(row_d, col_d, {1'b0, run_d}, payload_byte, 8'd0, 1'b0,
							eff_w, eff_h);
						if (e.write_valid) begin r0 = e; cnt = 2'd1; end
						col_d = adv(col_d, {1'b0, run_d});
						run_d = '0;
						ev_run = 1'b1;
					end
				end
				P_FILL2: begin
					n = {run_d, 1'b0};
					e = span(row_d, col_d, (n > 9'd254) ? 9'd254 : n, fill_d,
						payload_byte, 1'b1, eff_w, eff_h);
					if (e.write_valid) begin r0 = e; cnt = 2'd1; end
					col_d = adv(col_d, n);
					run_d = '0;
					ev_pkt = 1'b1;
				end
				P_COPY: begin
					e = span(row_d, col_d, 9'd1, payload_byte, 8'd0, 1'b0, eff_w, eff_h);
					if (e.write_valid) begin r0 = e; cnt = 2'd1; end
					col_d = adv(col_d, 9'd1);
					if (col_d >= {5'b0, frame_width}) ev_line = 1'b1;
				end
				default: phase_d = P_IDLE;
			endcase

			// Resolve end-of-run, end-of-packet and end-of-line in model order.
			if (ev_run) begin
				if (kind_d == KIND_BRUN) begin
					if (col_d >= {5'b0, frame_width}) ev_line = 1'b1;
					else phase_d = P_COUNT;
				end else begin
					ev_pkt = 1'b1;
				end
			end
			if (ev_pkt) begin
				packets_d = packets_d - 16'd1;
				if (packets_d == 16'd0) ev_line = 1'b1; else phase_d = P_SKIP;
			end
			if (ev_line) begin
				if (kind_d == KIND_SS2 && edge_pend_d) begin
					if (frame_width != 11'd0) begin
						e = span(row_d, {5'b0, frame_width - 11'd1}, 9'd1, edge_val_d,
							8'd0, 1'b0, eff_w, eff_h);
						if (e.write_valid) begin
							if (cnt == 2'd0) r0 = e; else r1 = e;
							cnt = cnt + 2'd1;
						end
					end
					edge_pend_d = 1'b0;
				end
				row_d = row_d + 16'd1;
				lines_d = lines_d - 16'd1;
				col_d = '0;
				if (lines_d == 16'd0) done = 1'b1;
				else phase_d = (kind_d == KIND_COPY) ? P_COPY : P_LINE;
			end
		end

		if (done) begin
			phase_d = P_IDLE;
			if (cnt == 2'd0) begin
				r0 = '0;
				r0.chunk_done = 1'b1;
				cnt = 2'd1;
			end else if (cnt == 2'd1) begin
				r0.chunk_done = 1'b1;
			end else begin
				r1.chunk_done = 1'b1;
			end
		end

		push_out.push = step && (cnt != 2'd0);
		push_out.two  = (cnt == 2'd2);
		push_out.r0   = r0;
		push_out.r1   = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE; kind_q <= '0; lines_q <= '0; row_q <= '0; col_q <= '0;
			packets_q <= '0; run_q <= '0; low_q <= '0; fill_q <= '0;
			edge_pend_q <= 1'b0; edge_val_q <= '0;
		end else if (step) begin
			phase_q <= phase_d; kind_q <= kind_d; lines_q <= lines_d; row_q <= row_d;
			col_q <= col_d; packets_q <= packets_d; run_q <= run_d; low_q <= low_d;
			fill_q <= fill_d; edge_pend_q <= edge_pend_d; edge_val_q <= edge_val_d;
		end
	end

endmodule

@@ design/fcd_res_queue.sv @@
module fcd_res_queue import fcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  fcd_push_t push_in,
	output logic      room_two,
	output logic      out_valid,
	output fcd_res_t  out_res,
	input  logic      out_ready
);

	fcd_res_t   mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] count_q;
	logic       pop;
	logic [2:0] n_in;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != 3'd0);
	assign out_res   = mem_q[rd_q];
	assign room_two  = (count_q <= 3'd2);
	assign n_in      = push_in.push ? (push_in.two ? 3'd2 : 3'd1) : 3'd0;

	always_ff @(posedge clk) begin
		if (push_in.push) begin
			mem_q[wr_q] <= push_in.r0;
			if (push_in.two) mem_q[wr_q + 2'd1] <= push_in.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + n_in[1:0];
			if (pop) rd_q <= rd_q + 2'd1;
			count_q <= count_q + n_in - {2'b0, pop};
		end
	end

endmodule

@@ design/flic_frame_chunk_decoder.sv @@
// FLIC image chunk decoder.
// Input stream (s_axis_*): one payload byte per transaction in tdata; tuser carries
// the chunk kind (0 byte run, 1 line delta, 2 word delta, 3 raw copy) and a
// first-byte flag that opens a new chunk and abandons any open one.
// Output stream (m_axis_*): one span write per transaction; tuser is the write flag,
// tlast marks the transaction that completes the chunk (a done-only transaction
// has tuser low and tdata zero).
// Config (cfg_*): index 0 frame width, index 1 frame height; always ready. Write
// only while the decoder is idle.
// Throughput: one byte per cycle while the queue has room. A byte is held in the input
// register and parsed there; its results land in a four-entry result queue, which is
// registered, and the first result shows on the output from that queue. A byte yields
// at most two results, which the queue drains one per cycle while tready is high.
// Stall: when the receiver holds tready low the queue fills; the input register
// holds its byte until the queue has room for two results, and s_axis_tready drops.
// Reset: parser goes idle, queue empties, width 320 and height 200.
module flic_frame_chunk_decoder import fcd_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // [7:0] payload_byte
	input  logic [2:0]            s_axis_tuser,  // [1:0] chunk_kind, [2] first_byte
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [9:0] row, [19:10] column, [27:20] span_length, [35:28] byte_a,
	// [43:36] byte_b, [44] pattern_two, [47:45] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tuser,  // [0] write_valid
	output logic                  m_axis_tlast,  // chunk_done
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [10:0]           cfg_data
);

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	logic [10:0] width_q, height_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [2:0]  user_s1;
	logic        room_two, step;
	fcd_push_t   push;
	fcd_res_t    res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd320;
			height_q <= 11'd200;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Parse the held byte once the queue can absorb two results.
	assign step          = valid_s1 && room_two;
	assign s_axis_tready = !valid_s1 || room_two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (s_axis_tready) valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			user_s1 <= s_axis_tuser;
		end
	end

	fcd_parser #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.payload_byte (byte_s1),
		.chunk_kind   (user_s1[1:0]),
		.first_byte   (user_s1[2]),
		.frame_width  (width_q),
		.frame_height (height_q),
		.push_out     (push)
	);

	fcd_res_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_in   (push),
		.room_two  (room_two),
		.out_valid (m_axis_tvalid),
		.out_res   (res),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tdata = {3'b0, res.pattern_two, res.byte_b, res.byte_a,
		res.span_length, res.column, res.row};
	assign m_axis_tuser = res.write_valid;
	assign m_axis_tlast = res.chunk_done;

endmodule

@@ design/fcd_checker.sv @@
module fcd_checker import fcd_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tuser,
	input logic                  m_axis_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transaction changed while stalled");

	a_bare_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
		else $error("result without a write is not a done mark");

	a_bare_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("done-only result carries data");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[27:20] != 8'd0)
		else $error("span write of zero length");

endmodule

bind flic_frame_chunk_decoder fcd_checker u_fcd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

@@ bench/tb_flic_frame_chunk_decoder.sv @@
`timescale 1ns / 100ps

module tb_flic_frame_chunk_decoder;
	import fcd_pkg::*;

	localparam int MAX_W = 1024;
	localparam int MAX_H = 1024;
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;

	// Parser phases of the decoder
	typedef enum int {
		PH_IDLE, PH_H0, PH_H1, PH_H2, PH_H3, PH_LINE, PH_WHI, PH_SKIP,
		PH_COUNT, PH_LIT, PH_FILL, PH_FILL2, PH_COPY
	} parse_ph_t;

	typedef struct {
		logic [7:0] data;
		logic [1:0] kind;
		logic       first;
	} payload_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;
	logic [2:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_index = 1'b0;
	logic [10:0]           cfg_data = '0;

	flic_frame_chunk_decoder #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stimulus bookkeeping
	payload_t  byte_q[$];
	fcd_res_t  span_q[$];
	payload_t  in_flight;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        errors = 0;
	int        bytes_sent = 0;
	int        spans_checked = 0;
	int        chunks_done = 0;
	int        cycles = 0;

	// Decoder state as predicted
	int unsigned frame_w = 320;
	int unsigned frame_h = 200;
	parse_ph_t   phase = PH_IDLE;
	logic [1:0]  kind_q = KIND_BRUN;
	int unsigned lines_left, cur_row, cur_col, packets_left, run_left;
	int unsigned hold_lo, fill_a, edge_pend, edge_val;
	fcd_res_t    step_out[2];
	int          n_out;
	bit          done_flag;

	function automatic void put_span(int unsigned row, int unsigned col, int unsigned len,
			int unsigned a, int unsigned b, bit two);
		int unsigned ew, eh;
		ew = frame_w < MAX_W ? frame_w : MAX_W;
		eh = frame_h < MAX_H ? frame_h : MAX_H;
		if (row >= eh || col >= ew || len == 0 || n_out >= 2)
			return;
		if (len > ew - col)
			len = ew - col;
		if (len > 255)
			len = 255;
		step_out[n_out] = '0;
		step_out[n_out].write_valid = 1'b1;
		step_out[n_out].row = row[9:0];
		step_out[n_out].column = col[9:0];
		step_out[n_out].span_length = len[7:0];
		step_out[n_out].byte_a = a[7:0];
		step_out[n_out].byte_b = two ? b[7:0] : 8'd0;
		step_out[n_out].pattern_two = two;
		n_out++;
	endfunction

	function automatic void move_col(int unsigned n);
		cur_col += n;
		if (cur_col > 32'hFFFF)
			cur_col = 32'hFFFF;
	endfunction

	function automatic void close_chunk();
		done_flag = 1'b1;
		phase = PH_IDLE;
	endfunction

	function automatic void close_line();
		if (kind_q == KIND_SS2 && edge_pend != 0) begin
			if (frame_w > 0)
				put_span(cur_row, frame_w - 1, 1, edge_val, 0, 1'b0);
			edge_pend = 0;
		end
		cur_row = (cur_row + 1) & 32'hFFFF;
		lines_left = (lines_left - 1) & 32'hFFFF;
		cur_col = 0;
		if (lines_left == 0)
			close_chunk();
		else
			phase = (kind_q == KIND_COPY) ? PH_COPY : PH_LINE;
	endfunction

	function automatic void close_packet();
		packets_left = (packets_left - 1) & 32'hFFFF;
		if (packets_left == 0)
			close_line();
		else
			phase = PH_SKIP;
	endfunction

	function automatic void close_run();
		if (kind_q == KIND_BRUN) begin
			if (cur_col >= frame_w)
				close_line();
			else
				phase = PH_COUNT;
		end else begin
			close_packet();
		end
	endfunction

	function automatic void parse_byte(int unsigned b);
		int unsigned w;
		case (phase)
			PH_H0: begin
				hold_lo = b;
				phase = PH_H1;
			end
			PH_H1: begin
				w = hold_lo | (b << 8);
				if (kind_q == KIND_LC) begin
					cur_row = w;
					phase = PH_H2;
				end else begin
					lines_left = w;
					if (w == 0) close_chunk(); else phase = PH_LINE;
				end
			end
			PH_H2: begin
				hold_lo = b;
				phase = PH_H3;
			end
			PH_H3: begin
				lines_left = hold_lo | (b << 8);
				if (lines_left == 0) close_chunk(); else phase = PH_LINE;
			end
			PH_LINE: begin
				cur_col = 0;
				if (kind_q == KIND_BRUN) begin
					if (cur_col >= frame_w) close_line(); else phase = PH_COUNT;
				end else if (kind_q == KIND_LC) begin
					packets_left = b;
					if (b == 0) close_line(); else phase = PH_SKIP;
				end else begin
					hold_lo = b;
					phase = PH_WHI;
				end
			end
			PH_WHI: begin
				w = hold_lo | (b << 8);
				phase = PH_LINE;
				if ((w & 32'hC000) == 32'hC000) begin
					// skip word: negative line count
					cur_row = (cur_row + ((32'h10000 - w) & 32'hFFFF)) & 32'hFFFF;
				end else if ((w & 32'hC000) == 32'h8000) begin
					edge_pend = 1;
					edge_val = w & 32'hFF;
				end else if ((w & 32'hC000) == 0) begin
					packets_left = w;
					cur_col = 0;
					if (w == 0) close_line(); else phase = PH_SKIP;
				end
			end
			PH_SKIP: begin
				move_col(b);
				phase = PH_COUNT;
			end
			PH_COUNT: begin
				if (b == 0) begin
					if (kind_q != KIND_BRUN)
						close_packet();
				end else if (b < 8'h80) begin
					if (kind_q == KIND_BRUN) begin
						run_left = b;
						phase = PH_FILL;
					end else begin
						run_left = (kind_q == KIND_SS2) ? 2 * b : b;
						phase = PH_LIT;
					end
				end else begin
					run_left = 256 - b;
					phase = (kind_q == KIND_BRUN) ? PH_LIT : PH_FILL;
				end
			end
			PH_LIT: begin
				put_span(cur_row, cur_col, 1, b, 0, 1'b0);
				move_col(1);
				run_left = (run_left - 1) & 32'hFF;
				if (run_left == 0)
					close_run();
			end
			PH_FILL: begin
				if (kind_q == KIND_SS2) begin
					fill_a = b;
					phase = PH_FILL2;
				end else begin
					put_span(cur_row, cur_col, run_left, b, 0, 1'b0);
					move_col(run_left);
					run_left = 0;
					close_run();
				end
			end
			PH_FILL2: begin
				// word fill: the span saturates at 254 but the column moves the full count
				w = 2 * run_left;
				put_span(cur_row, cur_col, w > 254 ? 254 : w, fill_a, b, 1'b1);
				move_col(w);
				run_left = 0;
				close_packet();
			end
			PH_COPY: begin
				put_span(cur_row, cur_col, 1, b, 0, 1'b0);
				move_col(1);
				if (cur_col >= frame_w)
					close_line();
			end
			default: phase = PH_IDLE;
		endcase
	endfunction

	// Work out the spans one accepted byte causes and queue them
	function automatic void predict_spans(payload_t it);
		n_out = 0;
		done_flag = 1'b0;
		if (it.first) begin
			kind_q = it.kind;
			cur_row = 0;
			cur_col = 0;
			packets_left = 0;
			run_left = 0;
			hold_lo = 0;
			fill_a = 0;
			edge_pend = 0;
			edge_val = 0;
			lines_left = frame_h;
			if (it.kind == KIND_BRUN) begin
				if (frame_h == 0) close_chunk(); else phase = PH_LINE;
			end else if (it.kind == KIND_COPY) begin
				if (frame_h == 0 || frame_w == 0) close_chunk(); else phase = PH_COPY;
			end else begin
				lines_left = 0;
				phase = PH_H0;
			end
			if (!done_flag)
				parse_byte({24'b0, it.data});
		end else begin
			if (phase == PH_IDLE)
				return;
			parse_byte({24'b0, it.data});
		end
		if (done_flag) begin
			if (n_out > 0) begin
				step_out[n_out - 1].chunk_done = 1'b1;
			end else begin
				step_out[0] = '0;
				step_out[0].chunk_done = 1'b1;
				n_out = 1;
			end
		end
		for (int i = 0; i < n_out; i++)
			span_q.push_back(step_out[i]);
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	// Driver: hold the byte while stalled, otherwise advance or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_spans(in_flight);
				bytes_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_flight = byte_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= in_flight.data;
					s_axis_tuser <= {in_flight.first, in_flight.kind};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random back-pressure, compare each span transaction with the oldest expectation
	always @(posedge clk) begin
		fcd_res_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (span_q.size() == 0) begin
					report_mismatch("spans pending", 1, 0);
				end else begin
					want = span_q.pop_front();
					spans_checked++;
					if (m_axis_tlast)
						chunks_done++;
					if (m_axis_tuser !== want.write_valid)
						report_mismatch("write_valid", m_axis_tuser, want.write_valid);
					if (m_axis_tdata[9:0] !== want.row)
						report_mismatch("row", m_axis_tdata[9:0], want.row);
					if (m_axis_tdata[19:10] !== want.column)
						report_mismatch("column", m_axis_tdata[19:10], want.column);
					if (m_axis_tdata[27:20] !== want.span_length)
						report_mismatch("span_length", m_axis_tdata[27:20], want.span_length);
					if (m_axis_tdata[35:28] !== want.byte_a)
						report_mismatch("byte_a", m_axis_tdata[35:28], want.byte_a);
					if (m_axis_tdata[43:36] !== want.byte_b)
						report_mismatch("byte_b", m_axis_tdata[43:36], want.byte_b);
					if (m_axis_tdata[44] !== want.pattern_two)
						report_mismatch("pattern_two", m_axis_tdata[44], want.pattern_two);
					if (m_axis_tlast !== want.chunk_done)
						report_mismatch("chunk_done", m_axis_tlast, want.chunk_done);
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	bit   next_first;
	int   gen_count;
	int   gen_budget;

	task automatic push_byte(int unsigned b, logic [1:0] k);
		payload_t it;
		it.data = b[7:0];
		it.kind = k;
		it.first = next_first;
		next_first = 1'b0;
		byte_q.push_back(it);
		gen_count++;
	endtask

	function automatic bit room();
		return gen_count < gen_budget;
	endfunction

	// Byte run: one ignored byte per line, then packets until the line is full
	task automatic gen_brun();
		int unsigned col, c;
		for (int l = 0; l < frame_h && room(); l++) begin
			push_byte($urandom_range(255), KIND_BRUN);
			col = 0;
			while (col < frame_w && room()) begin
				case ($urandom_range(9))
					0: push_byte(0, KIND_BRUN);
					1, 2, 3, 4: begin
						c = ($urandom_range(15) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 12);
						push_byte(c, KIND_BRUN);
						push_byte($urandom_range(255), KIND_BRUN);
						col += c;
					end
					default: begin
						c = ($urandom_range(30) == 0) ? 128 : $urandom_range(1, 6);
						push_byte(256 - c, KIND_BRUN);
						for (int i = 0; i < c; i++)
							push_byte($urandom_range(255), KIND_BRUN);
						col += c;
					end
				endcase
			end
		end
	endtask

	// One packet body of a line delta or word delta
	task automatic gen_packet(logic [1:0] k);
		int unsigned c;
		push_byte(($urandom_range(20) == 0) ? $urandom_range(255) : $urandom_range(12), k);
		case ($urandom_range(6))
			0: push_byte(0, k);
			1, 2, 3: begin
				c = ($urandom_range(40) == 0) ? 127 : $urandom_range(1, 5);
				push_byte(c, k);
				for (int i = 0; i < (k == KIND_SS2 ? 2 * c : c); i++)
					push_byte($urandom_range(255), k);
			end
			default: begin
				c = ($urandom_range(10) == 0) ? 128 : $urandom_range(1, 20);
				push_byte(256 - c, k);
				push_byte($urandom_range(255), k);
				if (k == KIND_SS2)
					push_byte($urandom_range(255), k);
			end
		endcase
	endtask

	task automatic gen_lc();
		int unsigned row, lines, p;
		row = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(frame_h + 2);
		lines = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
		push_byte(row & 8'hFF, KIND_LC);
		push_byte(row >> 8, KIND_LC);
		push_byte(lines & 8'hFF, KIND_LC);
		push_byte(lines >> 8, KIND_LC);
		for (int l = 0; l < lines && room(); l++) begin
			p = $urandom_range(3);
			push_byte(p, KIND_LC);
			for (int i = 0; i < p && room(); i++)
				gen_packet(KIND_LC);
		end
	endtask

	task automatic gen_ss2();
		int unsigned lines, p, w;
		lines = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
		push_byte(lines & 8'hFF, KIND_SS2);
		push_byte(lines >> 8, KIND_SS2);
		for (int l = 0; l < lines && room(); l++) begin
			// optional skip, last-pixel and undefined words ahead of the packet count
			for (int e = $urandom_range(2); e > 0; e--) begin
				case ($urandom_range(2))
					0: w = 32'h10000 - $urandom_range(1, 3);
					1: w = 32'h8000 | $urandom_range(255);
					default: w = 32'h4000 | $urandom_range(16'h3FFF);
				endcase
				push_byte(w & 8'hFF, KIND_SS2);
				push_byte((w >> 8) & 8'hFF, KIND_SS2);
			end
			p = $urandom_range(3);
			push_byte(p, KIND_SS2);
			push_byte(0, KIND_SS2);
			for (int i = 0; i < p && room(); i++)
				gen_packet(KIND_SS2);
		end
	endtask

	task automatic gen_chunk();
		logic [1:0] k;
		k = 2'($urandom_range(3));
		next_first = 1'b1;
		gen_budget = gen_count + $urandom_range(12, 160);
		case (k)
			KIND_BRUN: gen_brun();
			KIND_LC:   gen_lc();
			KIND_SS2:  gen_ss2();
			default: begin
				push_byte($urandom_range(255), KIND_COPY);
				for (int i = 1; i < frame_w * frame_h && room(); i++)
					push_byte($urandom_range(255), KIND_COPY);
			end
		endcase
		// stray bytes after the chunk, ignored when the parser is idle
		if ($urandom_range(6) == 0)
			for (int i = $urandom_range(1, 4); i > 0; i--)
				push_byte($urandom_range(255), 2'($urandom_range(3)));
	endtask

	task automatic write_reg(logic idx, logic [10:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_WIDTH)
			frame_w = {21'b0, value};
		else
			frame_h = {21'b0, value};
	endtask

	// Wait for every byte to be taken and every span to arrive, then let the parser settle
	task automatic drain();
		do @(negedge clk); while (byte_q.size() > 0 || s_axis_tvalid || span_q.size() > 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic push_raw(int unsigned b, logic [1:0] k, bit f);
		next_first = f;
		push_byte(b, k);
	endtask

	int unsigned widths[8]  = '{16, 1, 1024, 2047, 0, 33, 320, 7};
	int unsigned heights[8] = '{4, 1, 1024, 2047, 0, 9, 200, 3};

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening with a 16 by 4 frame
		write_reg(REG_WIDTH, 11'd16);
		write_reg(REG_HEIGHT, 11'd4);
		gen_budget = 1 << 30;
		push_raw(8'h55, KIND_BRUN, 1'b0);       // idle byte, ignored
		push_raw(0, KIND_LC, 1'b1);             // empty line delta
		push_raw(0, KIND_LC, 1'b0);
		push_raw(0, KIND_LC, 1'b0);
		push_raw(0, KIND_LC, 1'b0);
		push_raw(1, KIND_SS2, 1'b1);            // word delta, one line
		push_raw(0, KIND_SS2, 1'b0);
		push_raw(8'h00, KIND_SS2, 1'b0);        // undefined word
		push_raw(8'h40, KIND_SS2, 1'b0);
		push_raw(8'hAB, KIND_SS2, 1'b0);        // last-pixel mark
		push_raw(8'h80, KIND_SS2, 1'b0);
		push_raw(8'hFF, KIND_SS2, 1'b0);        // skip one line
		push_raw(8'hFF, KIND_SS2, 1'b0);
		push_raw(1, KIND_SS2, 1'b0);            // one packet
		push_raw(0, KIND_SS2, 1'b0);
		push_raw(2, KIND_SS2, 1'b0);
		push_raw(8'h80, KIND_SS2, 1'b0);        // fill of 128 pairs
		push_raw(8'h12, KIND_SS2, 1'b0);
		push_raw(8'h34, KIND_SS2, 1'b0);
		push_raw(8'hFF, KIND_BRUN, 1'b1);       // byte run: zero count, then one literal
		push_raw(8'h00, KIND_BRUN, 1'b0);
		push_raw(8'hFF, KIND_BRUN, 1'b0);
		push_raw(8'h00, KIND_BRUN, 1'b0);
		push_raw(8'hFF, KIND_COPY, 1'b1);       // copy, abandoned by the next chunk
		drain();

		foreach (widths[s]) begin
			write_reg(REG_WIDTH, 11'(widths[s]));
			write_reg(REG_HEIGHT, 11'(heights[s]));
			for (int mode = 0; mode < 3; mode++) begin
				send_idle_pct = (mode == 0) ? 24 : (mode == 1) ? 53 : 0;
				recv_idle_pct = (mode == 0) ? 53 : (mode == 1) ? 24 : 0;
				gen_count = 0;
				while (gen_count < 40)
					gen_chunk();
				drain();
			end
		end

		$display("%0d payload bytes over %0d frame sizes, %0d spans checked, %0d chunks completed",
			bytes_sent, $size(widths) + 1, spans_checked, chunks_done);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
design/fcd_pkg.sv
design/fcd_parser.sv
design/fcd_res_queue.sv
design/flic_frame_chunk_decoder.sv
design/fcd_checker.sv
bench/tb_flic_frame_chunk_decoder.sv
